>>> hdl/brfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfp_pkg
// Shared constants, command codes and control/status types of the byte ring
// FIFO with peek.
// ----------------------------------------------------------------------------
package brfp_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned CNT_W             = 8;
  localparam int unsigned CMD_W             = 3;
  localparam int unsigned SIZE_W            = 9;
  localparam int unsigned RING_MAX          = 256;
  localparam int unsigned DEPTH_DEF         = 256;
  localparam int unsigned MAX_POP_BURST_DEF = 16;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [CNT_W-1:0]  CNT_SAT    = 8'd255;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEAD_F = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HEAD_B = 3'd5;
  localparam logic [CMD_W-1:0] CMD_STATUS = 3'd6;

  typedef struct packed {
    logic do_single;
    logic rd_pop;
    logic rd_peek;
    logic emit_peek;
    logic emit_pop;
  } ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic pop_empty;
    logic pop_last;
  } status_t;

endpackage

>>> hdl/brfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfp_ctrl
// Command sequencer: accepts words, runs peek reads and pop bursts.
// ----------------------------------------------------------------------------
module brfp_ctrl
  import brfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  status_t          status_i,
  output logic             in_ready_o,
  output ctrl_t            ctrl_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PEEK = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_PEEK) begin
            ctrl_o.rd_peek = 1'b1;
            state_d        = ST_PEEK;
          end else if (cmd_i == CMD_POP && !status_i.pop_empty) begin
            ctrl_o.rd_pop = 1'b1;
            state_d       = ST_POP;
          end else begin
            ctrl_o.do_single = 1'b1;
          end
        end
      end
      ST_PEEK: begin
        if (status_i.slot_free) begin
          ctrl_o.emit_peek = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_POP: begin
        if (status_i.slot_free) begin
          ctrl_o.emit_pop = 1'b1;
          if (status_i.pop_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/brfp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfp_dp
// Ring store, pointers, fill count, burst state and result register.
// ----------------------------------------------------------------------------
module brfp_dp
  import brfp_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned MAX_POP_BURST = MAX_POP_BURST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_size_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              write_last_i,
  input  ctrl_t             ctrl_i,
  output status_t           status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] data_out_o,
  output logic              ok_o,
  output logic [CNT_W-1:0]  moved_count_o,
  output logic [CNT_W-1:0]  used_count_o,
  output logic [CNT_W-1:0]  free_count_o,
  output logic              last_o
);

  localparam int unsigned STORE_DEPTH = (DEPTH < RING_MAX) ? DEPTH : RING_MAX;
  localparam int unsigned PTR_W       = $clog2(STORE_DEPTH);
  localparam int unsigned SUM_W       = SIZE_W + 1;
  localparam int unsigned REM_W       = $clog2(MAX_POP_BURST + 1);
  localparam logic [SIZE_W-1:0] STORE_SIZE = SIZE_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0]  BURST_MAX  = CNT_W'(MAX_POP_BURST);

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] sum,
                                                input logic [SIZE_W-1:0] sz);
    logic [SUM_W-1:0] r;
    r = sum;
    if (sum >= SUM_W'(sz)) begin
      r = sum - SUM_W'(sz);
    end
    return PTR_W'(r);
  endfunction

  logic [BYTE_W-1:0]      mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [BYTE_W-1:0]      rdata_q;
  logic                   rvld_q;

  logic [SIZE_W-1:0] size_q;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  logic              ref_q, ref_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W-1:0]  pcnt_q, pcnt_d;
  logic              hit_q, hit_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_ok_q;
  logic [CNT_W-1:0]  out_moved_q;
  logic [CNT_W-1:0]  out_used_q;
  logic [CNT_W-1:0]  out_free_q;
  logic              out_last_q;

  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W-1:0] used_ext;
  logic [PTR_W-1:0]  free_now;
  logic [PTR_W-1:0]  free_d;
  logic [CNT_W-1:0]  amt_used;
  logic [CNT_W-1:0]  amt_free;
  logic [CNT_W-1:0]  burst_n;
  logic [CNT_W-1:0]  pop_k;
  logic [CNT_W-1:0]  acc_inc;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  peek_addr;
  logic              peek_hit;
  logic              push_ok;
  logic              slot_free;

  logic              wr_en;
  logic              rd_en;
  logic [PTR_W-1:0]  raddr;
  logic              load;
  logic [BYTE_W-1:0] res_data;
  logic              res_ok;
  logic [CNT_W-1:0]  res_moved;
  logic              res_last;

  assign size_eff = (size_q < SIZE_MIN)   ? SIZE_MIN :
                    (size_q > STORE_SIZE) ? STORE_SIZE : size_q;
  assign used_ext = SIZE_W'(used_q);
  assign free_now = PTR_W'(size_eff - SIZE_W'(1) - used_ext);

  assign amt_used = (SIZE_W'(count_i) < used_ext) ? count_i : CNT_W'(used_q);
  assign amt_free = (count_i < CNT_W'(free_now)) ? count_i : CNT_W'(free_now);
  assign burst_n  = (count_i < BURST_MAX) ? count_i : BURST_MAX;
  assign pop_k    = (SIZE_W'(burst_n) < used_ext) ? burst_n : CNT_W'(used_q);

  assign acc_inc   = (acc_q == CNT_SAT) ? acc_q : acc_q + CNT_W'(1);
  assign head_inc  = wrap_ptr(SUM_W'(head_q) + SUM_W'(1), size_eff);
  assign tail_inc  = wrap_ptr(SUM_W'(tail_q) + SUM_W'(1), size_eff);
  assign peek_addr = wrap_ptr(SUM_W'(tail_q) + SUM_W'(count_i), size_eff);
  assign peek_hit  = SIZE_W'(count_i) < used_ext;
  assign push_ok   = !ref_q && (free_now != '0);

  assign slot_free = !out_valid_q || out_ready_i;

  assign status_o.slot_free = slot_free;
  assign status_o.pop_empty = (pop_k == '0);
  assign status_o.pop_last  = (rem_q == REM_W'(1));

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    used_d    = used_q;
    acc_d     = acc_q;
    ref_d     = ref_q;
    rem_d     = rem_q;
    pcnt_d    = pcnt_q;
    hit_d     = hit_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    raddr     = tail_q;
    load      = 1'b0;
    res_data  = '0;
    res_ok    = 1'b0;
    res_moved = '0;
    res_last  = 1'b1;

    if (ctrl_i.do_single) begin
      load = 1'b1;
      unique case (cmd_i)
        CMD_PUSH: begin
          if (push_ok) begin
            wr_en     = 1'b1;
            head_d    = head_inc;
            used_d    = used_q + PTR_W'(1);
            res_data  = data_byte_i;
            res_ok    = 1'b1;
            res_moved = acc_inc;
            acc_d     = acc_inc;
          end else begin
            res_moved = acc_q;
            ref_d     = 1'b1;
          end
          if (write_last_i) begin
            acc_d = '0;
            ref_d = 1'b0;
          end
        end
        CMD_DROP: begin
          tail_d    = wrap_ptr(SUM_W'(tail_q) + SUM_W'(amt_used), size_eff);
          used_d    = used_q - PTR_W'(amt_used);
          res_ok    = (amt_used == count_i);
          res_moved = amt_used;
        end
        CMD_HEAD_F: begin
          head_d    = wrap_ptr(SUM_W'(head_q) + SUM_W'(amt_free), size_eff);
          used_d    = used_q + PTR_W'(amt_free);
          res_ok    = (amt_free == count_i);
          res_moved = amt_free;
        end
        CMD_HEAD_B: begin
          head_d    = wrap_ptr(SUM_W'(head_q) + SUM_W'(size_eff) - SUM_W'(amt_used),
                               size_eff);
          used_d    = used_q - PTR_W'(amt_used);
          res_ok    = (amt_used == count_i);
          res_moved = amt_used;
        end
        CMD_STATUS: begin
          res_ok = 1'b1;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end

    if (ctrl_i.rd_pop) begin
      rd_en  = 1'b1;
      raddr  = tail_q;
      rem_d  = REM_W'(pop_k);
      pcnt_d = '0;
    end

    if (ctrl_i.rd_peek) begin
      rd_en = 1'b1;
      raddr = peek_hit ? peek_addr : tail_q;
      hit_d = peek_hit;
    end

    if (ctrl_i.emit_peek) begin
      load     = 1'b1;
      res_data = (hit_q && rvld_q) ? rdata_q : '0;
      res_ok   = hit_q;
    end

    if (ctrl_i.emit_pop) begin
      load      = 1'b1;
      res_data  = rvld_q ? rdata_q : '0;
      res_ok    = 1'b1;
      res_moved = CNT_W'(pcnt_q) + CNT_W'(1);
      res_last  = status_o.pop_last;
      used_d    = used_q - PTR_W'(1);
      tail_d    = tail_inc;
      rem_d     = rem_q - REM_W'(1);
      pcnt_d    = pcnt_q + REM_W'(1);
      if (!status_o.pop_last) begin
        rd_en = 1'b1;
        raddr = tail_inc;
      end
    end
  end

  assign free_d = PTR_W'(size_eff - SIZE_W'(1) - SIZE_W'(used_d));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[head_q] <= data_byte_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (load) begin
      out_data_q  <= res_data;
      out_ok_q    <= res_ok;
      out_moved_q <= res_moved;
      out_used_q  <= CNT_W'(used_d);
      out_free_q  <= CNT_W'(free_d);
      out_last_q  <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      acc_q       <= '0;
      ref_q       <= 1'b0;
      rem_q       <= '0;
      pcnt_q      <= '0;
      hit_q       <= 1'b0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_size_i;
        head_q <= '0;
        tail_q <= '0;
        used_q <= '0;
        acc_q  <= '0;
        ref_q  <= 1'b0;
        vld_q  <= '0;
      end else begin
        head_q <= head_d;
        tail_q <= tail_d;
        used_q <= used_d;
        acc_q  <= acc_d;
        ref_q  <= ref_d;
        if (wr_en) begin
          vld_q[head_q] <= 1'b1;
        end
      end
      rem_q  <= rem_d;
      pcnt_q <= pcnt_d;
      hit_q  <= hit_d;
      if (rd_en) begin
        rvld_q <= vld_q[raddr];
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = out_data_q;
  assign ok_o          = out_ok_q;
  assign moved_count_o = out_moved_q;
  assign used_count_o  = out_used_q;
  assign free_count_o  = out_free_q;
  assign last_o        = out_last_q;

endmodule

>>> hdl/byte_ring_fifo_with_peek_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_core
// Byte ring FIFO with push bursts, pop bursts, peek, drop and head moves.
//
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   cmd_i, data_byte_i, count_i,
//                                          write_last_i
// out       out  out_valid_o / out_ready_i data_out_o, ok_o, moved_count_o,
//                                          used_count_o, free_count_o, last_o
// cfg       in   cfg_valid_i / cfg_ready_o cfg_size_in_use_i
//
// Push, drop, head moves, status, unused codes, empty pops: result registered
// in the cycle after the word is taken. Peek: store read register, then output
// register. Pop of k bytes: one byte per cycle from the single store read
// port; low out_ready_i holds the result and pauses the burst. A new word is
// taken once the last result is in the output register and that register is
// free or being emptied. Reset and size writes clear the store valid bits.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek_core
  import brfp_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned MAX_POP_BURST = MAX_POP_BURST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] cfg_size_in_use_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              write_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] data_out_o,
  output logic              ok_o,
  output logic [CNT_W-1:0]  moved_count_o,
  output logic [CNT_W-1:0]  used_count_o,
  output logic [CNT_W-1:0]  free_count_o,
  output logic              last_o
);

  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready_o = 1'b1;

  brfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  brfp_dp #(
    .DEPTH         (DEPTH),
    .MAX_POP_BURST (MAX_POP_BURST)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_size_i    (cfg_size_in_use_i),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .count_i       (count_i),
    .write_last_i  (write_last_i),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .data_out_o    (data_out_o),
    .ok_o          (ok_o),
    .moved_count_o (moved_count_o),
    .used_count_o  (used_count_o),
    .free_count_o  (free_count_o),
    .last_o        (last_o)
  );

  a_burst_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> ok_o && (moved_count_o != 8'd0))
    else $error("non-final result without a popped byte");

  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input taken during a pop burst");

  a_peek_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_PEEK) |=> !in_ready_o)
    else $error("input taken while a peek read is pending");

endmodule

>>> bench/byte_ring_fifo_with_peek_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_core_tb
// Self-checking bench for the byte ring FIFO with peek. A queue-fed driver
// offers command words, a scoreboard predicts every result from a private copy
// of the ring, and a monitor checks each result field by field. Ring sizes are
// rewritten between phases, including the clamped extremes. The bench also
// stalls the result side for a long stretch while words keep coming.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek_core_tb;
  import brfp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_WORDS = 4;
  localparam int unsigned MAX_PRINT   = 50;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              wlast;
  } word_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              ok;
    logic [CNT_W-1:0]  moved;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
    logic              last;
  } result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_size_in_use_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i = CMD_STATUS;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic [CNT_W-1:0]  count_i = '0;
  logic              write_last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] data_out_o;
  logic              ok_o;
  logic [CNT_W-1:0]  moved_count_o;
  logic [CNT_W-1:0]  used_count_o;
  logic [CNT_W-1:0]  free_count_o;
  logic              last_o;

  byte_ring_fifo_with_peek_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_size_in_use_i (cfg_size_in_use_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .data_byte_i       (data_byte_i),
    .count_i           (count_i),
    .write_last_i      (write_last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .data_out_o        (data_out_o),
    .ok_o              (ok_o),
    .moved_count_o     (moved_count_o),
    .used_count_o      (used_count_o),
    .free_count_o      (free_count_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scoreboard copy of the ring
  logic [BYTE_W-1:0] ring_mem [0:RING_MAX-1];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       burst_cnt;
  bit                burst_refused;
  logic [SIZE_W-1:0] size_reg;

  word_t   pending_words[$];
  result_t due_results[$];

  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned results_out = 0;
  int unsigned size_writes = 0;
  int unsigned deepest_fill = 0;
  int unsigned stuck = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned out_hold = 0;
  int unsigned hold_req = 0;
  bit          in_taken = 1'b0;
  bit          no_idle = 1'b0;

  function automatic int unsigned eff_size();
    int unsigned s;
    s = size_reg;
    if (s < SIZE_MIN) s = SIZE_MIN;
    if (s > RING_MAX) s = RING_MAX;
    return s;
  endfunction

  function automatic int unsigned ring_used();
    if (ring_tail <= ring_head) return ring_head - ring_tail;
    return (eff_size() - ring_tail) + ring_head;
  endfunction

  function automatic int unsigned ring_free();
    return eff_size() - 1 - ring_used();
  endfunction

  function automatic int unsigned ring_adv(int unsigned p, int unsigned n);
    int unsigned q;
    q = p + n;
    if (q >= eff_size()) q = q - eff_size();
    return q;
  endfunction

  function automatic int unsigned min2(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  task automatic clear_ring();
    for (int i = 0; i < RING_MAX; i++) ring_mem[i] = '0;
    ring_head     = 0;
    ring_tail     = 0;
    burst_cnt     = 0;
    burst_refused = 1'b0;
  endtask

  task automatic add_result(int unsigned data, bit ok, int unsigned moved, bit last);
    result_t r;
    r.data  = 8'(data);
    r.ok    = ok;
    r.moved = 8'(moved);
    r.used  = 8'(ring_used());
    r.free  = 8'(ring_free());
    r.last  = last;
    if (ring_used() > deepest_fill) deepest_fill = ring_used();
    due_results.push_back(r);
  endtask

  task automatic predict_ring(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                              logic [CNT_W-1:0] count, logic wlast);
    int unsigned s, k, amt;
    bit          okb;
    logic [BYTE_W-1:0] b;
    s = eff_size();
    if (ring_head >= s) ring_head = 0;
    if (ring_tail >= s) ring_tail = 0;
    case (cmd)
      CMD_PUSH: begin
        okb = 1'b0;
        if (!burst_refused && ring_free() > 0) begin
          ring_mem[ring_head] = data;
          ring_head = ring_adv(ring_head, 1);
          if (burst_cnt < CNT_SAT) burst_cnt++;
          okb = 1'b1;
        end else begin
          burst_refused = 1'b1;
        end
        add_result(okb ? data : 0, okb, burst_cnt, 1'b1);
        if (wlast) begin
          burst_cnt     = 0;
          burst_refused = 1'b0;
        end
      end
      CMD_POP: begin
        k = min2(min2(count, MAX_POP_BURST_DEF), ring_used());
        if (k == 0) begin
          add_result(0, 1'b0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < k; i++) begin
            b = ring_mem[ring_tail];
            ring_tail = ring_adv(ring_tail, 1);
            add_result(b, 1'b1, i + 1, (i + 1 == k));
          end
        end
      end
      CMD_PEEK: begin
        if (count < ring_used()) add_result(ring_mem[ring_adv(ring_tail, count)], 1'b1, 0, 1'b1);
        else add_result(0, 1'b0, 0, 1'b1);
      end
      CMD_DROP: begin
        amt = min2(count, ring_used());
        ring_tail = ring_adv(ring_tail, amt);
        add_result(0, amt == count, amt, 1'b1);
      end
      CMD_HEAD_F: begin
        amt = min2(count, ring_free());
        ring_head = ring_adv(ring_head, amt);
        add_result(0, amt == count, amt, 1'b1);
      end
      CMD_HEAD_B: begin
        amt = min2(count, ring_used());
        ring_head = ring_adv(ring_head, s - amt);
        add_result(0, amt == count, amt, 1'b1);
      end
      CMD_STATUS: add_result(0, 1'b1, 0, 1'b1);
      default: add_result(0, 1'b0, 0, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINT) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_out, name, got, want));
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // driver: offer the next pending word, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap = no_idle ? 0 : pick_gap();
      end
      if (in_gap > 0 || pending_words.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        word_t w;
        w = pending_words.pop_front();
        in_valid_i   <= 1'b1;
        cmd_i        <= w.cmd;
        data_byte_i  <= w.data;
        count_i      <= w.count;
        write_last_i <= w.wlast;
      end
    end
  end

  // receiver: random back-pressure plus the requested long hold
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      out_hold = hold_req;
      hold_req = 0;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 15) out_gap = pick_gap() + 1;
    end
  end

  // monitor: predict on each taken word, check each taken result
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_ring(cmd_i, data_byte_i, count_i, write_last_i);
        in_taken = 1'b1;
        words_in++;
      end
      if (out_valid_o && out_ready_i) begin
        results_out++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing due", results_out));
        end else begin
          w = due_results.pop_front();
          check_field("data_out", data_out_o, w.data);
          check_field("ok", {7'd0, ok_o}, {7'd0, w.ok});
          check_field("moved_count", moved_count_o, w.moved);
          check_field("used_count", used_count_o, w.used);
          check_field("free_count", free_count_o, w.free);
          check_field("last", {7'd0, last_o}, {7'd0, w.last});
        end
      end
    end
  end

  // watchdog: count cycles with work outstanding and no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) ||
        !(pending_words.size() != 0 || due_results.size() != 0 || in_valid_i || cfg_valid_i))
      stuck = 0;
    else
      stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
      $display("byte_ring_fifo_with_peek_core_tb: errors");
      $finish;
    end
  end

  task automatic add_word(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                          logic [CNT_W-1:0] count, logic wlast);
    word_t w;
    w.cmd   = cmd;
    w.data  = data;
    w.count = count;
    w.wlast = wlast;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    @(negedge clk_i);
    cfg_size_in_use_i <= v;
    cfg_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = v;
    clear_ring();
    size_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CNT_W-1:0] draw_count(int unsigned hi);
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, min2(hi, 255)));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned made, r, len, es;
    es   = eff_size();
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, min2(es + 2, 10));
        else len = $urandom_range(1, min2(es + 1, 6));
        for (int unsigned i = 0; i < len; i++)
          add_word(CMD_PUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   (i == len - 1) ? ($urandom_range(0, 99) < 85) : 1'b0);
        made += len;
      end else begin
        logic [CMD_W-1:0] c;
        logic [CNT_W-1:0] cnt;
        if (r < 58)      begin c = CMD_POP;    cnt = draw_count(MAX_POP_BURST_DEF + 2); end
        else if (r < 68) begin c = CMD_PEEK;   cnt = draw_count(es); end
        else if (r < 76) begin c = CMD_DROP;   cnt = draw_count(es); end
        else if (r < 84) begin c = CMD_HEAD_F; cnt = draw_count(es); end
        else if (r < 92) begin c = CMD_HEAD_B; cnt = draw_count(es); end
        else if (r < 99) begin c = CMD_STATUS; cnt = draw_count(255); end
        else             begin c = CMD_UNUSED; cnt = draw_count(255); end
        add_word(c, 8'($urandom_range(0, 255)), cnt, 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [10];
    size_reg = SIZE_RESET;
    clear_ring();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset size, empty ring and field extremes
    add_word(CMD_STATUS, 8'h00, 8'h00, 1'b0);
    add_word(CMD_POP,    8'h00, 8'h01, 1'b0);
    add_word(CMD_PEEK,   8'h00, 8'h00, 1'b0);
    add_word(CMD_DROP,   8'h00, 8'h00, 1'b0);
    add_word(CMD_DROP,   8'h00, 8'h05, 1'b0);
    add_word(CMD_HEAD_B, 8'h00, 8'h03, 1'b0);
    add_word(CMD_PUSH,   8'h00, 8'h00, 1'b0);
    add_word(CMD_PUSH,   8'hFF, 8'hFF, 1'b1);
    add_word(CMD_PEEK,   8'h00, 8'h01, 1'b0);
    add_word(CMD_PEEK,   8'h00, 8'hFF, 1'b1);
    add_word(CMD_POP,    8'hFF, 8'hFF, 1'b1);
    add_word(CMD_HEAD_F, 8'h00, 8'hFF, 1'b0);
    add_word(CMD_HEAD_B, 8'h00, 8'hFF, 1'b0);
    add_word(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);
    add_word(CMD_POP,    8'h00, 8'h00, 1'b0);
    wait_drained();

    // directed: full ring and refused burst at size 4
    write_size(9'd4);
    add_word(CMD_PUSH,   8'hA1, 8'h00, 1'b0);
    add_word(CMD_PUSH,   8'hB2, 8'h00, 1'b0);
    add_word(CMD_PUSH,   8'hC3, 8'h00, 1'b0);
    add_word(CMD_PUSH,   8'hD4, 8'h00, 1'b0);
    add_word(CMD_POP,    8'h00, 8'h01, 1'b0);
    add_word(CMD_PUSH,   8'hE5, 8'h00, 1'b1);
    add_word(CMD_PUSH,   8'hF6, 8'h00, 1'b1);
    add_word(CMD_PEEK,   8'h00, 8'h02, 1'b0);
    add_word(CMD_HEAD_F, 8'h00, 8'h03, 1'b0);
    add_word(CMD_DROP,   8'h00, 8'hFF, 1'b0);
    wait_drained();

    // long burst that saturates the accepted count, with a long receiver stall
    write_size(SIZE_RESET);
    hold_req = LONG_HOLD;
    for (int i = 0; i < 240; i++) add_word(CMD_PUSH, 8'($urandom_range(0, 255)), 8'h00, 1'b0);
    add_word(CMD_POP, 8'h00, 8'd16, 1'b0);
    for (int i = 0; i < 16; i++)
      add_word(CMD_PUSH, 8'($urandom_range(0, 255)), 8'h00, (i == 15));
    add_word(CMD_POP, 8'h00, 8'd20, 1'b0);
    wait_drained();

    sizes = '{9'd2, 9'd0, 9'd1, 9'd3, 9'd5, 9'd17, 9'd100, 9'd256, 9'd511,
              9'($urandom_range(2, 40))};
    for (int p = 0; p < 10; p++) begin
      write_size(sizes[p]);
      no_idle = (p == 3);
      if (p == 0) begin
        queue_random(PHASE_WORDS / 2);
        wait_drained();
        queue_random(PHASE_WORDS / 2);
      end else begin
        queue_random(PHASE_WORDS);
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    $display("covered %0d words, %0d results, %0d size writes, deepest fill %0d bytes",
             words_in, results_out, size_writes, deepest_fill);
    $display("mismatches counted: %0d", errors);
    if (errors == 0) $display("byte_ring_fifo_with_peek_core_tb: clean");
    else $display("byte_ring_fifo_with_peek_core_tb: errors");
    $finish;
  end

endmodule

>>> byte_ring_fifo_with_peek_core.f
hdl/brfp_pkg.sv
hdl/brfp_ctrl.sv
hdl/brfp_dp.sv
hdl/byte_ring_fifo_with_peek_core.sv
bench/byte_ring_fifo_with_peek_core_tb.sv
